/* design/lfst_pkg.sv */
// ----------------------------------------------------------------------------
// lfst_pkg
// Shared types and constants for the lowest free slot table.
// ----------------------------------------------------------------------------
package lfst_pkg;

	// default table size and the width of one row of the used-bit memory
	localparam int DEPTH_DEF   = 64;
	localparam int ROW_BITS    = 16;
	// slots that hold a handle equal to their index after reset
	localparam int FIXED_SLOTS = 3;

	localparam int HANDLE_W = 16;
	localparam int INDEX_W  = 6;
	localparam int COUNT_W  = 7;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_CLONE = 2'd2,
		OP_GET   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_BADIDX   = 3'd2,
		ST_SRCEMPTY = 3'd3,
		ST_TGTBUSY  = 3'd4
	} status_t;

	// one-hot sequencer states
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_FIND = 4'b0100,
		S_SCAN = 4'b1000
	} state_t;

endpackage

/* design/lowest_free_slot_table.sv */
// ----------------------------------------------------------------------------
// lowest_free_slot_table
// Descriptor slot table with lowest-free allocation, free, clone and get.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// request   in         start & !busy          operation, handle_in, slot_index,
//                                             target_index, target_auto
// result    out        done (one cycle)       status, slot_out, handle_out,
//                                             handle_valid, free_count
//
// A request first reads the handle memory and the used-bit memory, then
// checks, writes back and registers the result together with done.
// When an allocate or clone fills the row of the lowest free slot, the
// sequencer goes on to find the next row with a free bit (S_FIND) and to
// read it (S_SCAN), or stops after S_FIND when no row has a free bit left.
// The row-full flags and row-valid flags live in flops, so reset needs no
// clearing pass. The receiver cannot stall; done is high for one cycle.
//
module lowest_free_slot_table
	import lfst_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          operation,
	input  logic [HANDLE_W-1:0] handle_in,
	input  logic [INDEX_W-1:0]  slot_index,
	input  logic [INDEX_W-1:0]  target_index,
	input  logic                target_auto,
	output logic                done,
	output logic [2:0]          status,
	output logic [INDEX_W-1:0]  slot_out,
	output logic [HANDLE_W-1:0] handle_out,
	output logic                handle_valid,
	output logic [COUNT_W-1:0]  free_count
);

	localparam int IW    = $clog2(DEPTH + 1);
	localparam int SW    = $clog2(DEPTH);
	localparam int RB    = (DEPTH < ROW_BITS) ? (2 ** SW) : ROW_BITS;
	localparam int BW    = $clog2(RB);
	localparam int NROWS = (DEPTH + RB - 1) / RB;
	localparam int RW    = (NROWS > 1) ? $clog2(NROWS) : 1;

	// bits past the end of the table count as used
	function automatic logic [RB-1:0] pad_of(input logic [RW-1:0] r);
		logic [RB-1:0] p;
		for (int b = 0; b < RB; b++) begin
			p[b] = (((32'(r) << BW) + 32'(b)) >= 32'(DEPTH));
		end
		return p;
	endfunction

	// used bits of a row never written since reset
	function automatic logic [RB-1:0] row_init(input logic [RW-1:0] r);
		logic [RB-1:0] v;
		v = '0;
		if (r == '0) begin
			v = RB'((1 << FIXED_SLOTS) - 1);
		end
		return v;
	endfunction

	// position of the lowest clear bit
	function automatic logic [BW-1:0] lz(input logic [RB-1:0] w);
		logic [BW-1:0] e;
		e = '0;
		for (int b = RB - 1; b >= 0; b--) begin
			if (!w[b]) begin
				e = BW'(b);
			end
		end
		return e;
	endfunction

	// memories
	logic [HANDLE_W-1:0] hnd_mem [DEPTH];
	logic [RB-1:0]       used_mem [NROWS];
	logic [HANDLE_W-1:0] hnd_rd_q;
	logic [RB-1:0]       used_rd_a_q, used_rd_b_q;

	// control state
	state_t                state_q;
	logic                  done_q;
	logic [IW-1:0]         lowest_q;
	logic [IW-1:0]         cnt_q;
	logic [NROWS-1:0]      row_valid_q;
	logic [NROWS-1:0]      row_full_q;
	logic [FIXED_SLOTS-1:0] init_q;
	logic [RW-1:0]         find_row_q;

	// captured request
	op_t                 op_s1;
	logic [HANDLE_W-1:0] hin_s1;
	logic                aut_s1, idx_ok_s1, dst_ok_s1, dst_low_s1;
	logic [SW-1:0]       idx_a_s1, dst_a_s1;
	logic [RW-1:0]       row_a_s1, row_b_s1;

	// result registers
	status_t             status_q;
	logic [INDEX_W-1:0]  slot_q;
	logic [HANDLE_W-1:0] hout_q;
	logic                hval_q;

	logic accept;
	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// first row with a free bit
	logic          find_any;
	logic [RW-1:0] find_row;

	always_comb begin
		find_any = |(~row_full_q);
		find_row = '0;
		for (int r = NROWS - 1; r >= 0; r--) begin
			if (!row_full_q[r]) begin
				find_row = RW'(r);
			end
		end
	end

	// request decode: addresses and range checks
	op_t           in_op;
	logic          in_auto, in_idx_ok, in_dst_ok, in_dst_low;
	logic [SW-1:0] in_idx_a, in_dst_a;
	logic [RW-1:0] in_row_a, in_row_b, rd_b_row;

	always_comb begin
		in_op     = op_t'(operation);
		in_auto   = (in_op == OP_ALLOC) || target_auto;
		in_idx_a  = SW'(32'(slot_index));
		in_idx_ok = (32'(slot_index) < 32'(DEPTH));
		if (in_auto) begin
			in_dst_a   = SW'(lowest_q);
			in_dst_ok  = (32'(lowest_q) != 32'(DEPTH));
			in_dst_low = 1'b1;
		end else begin
			in_dst_a   = SW'(32'(target_index));
			in_dst_ok  = (32'(target_index) < 32'(DEPTH));
			in_dst_low = (32'(target_index) == 32'(lowest_q));
		end
		in_row_a = RW'(in_idx_a >> BW);
		in_row_b = RW'(in_dst_a >> BW);
		rd_b_row = (state_q == S_FIND) ? find_row : in_row_b;
	end

	// check and modify for the request in flight
	logic [RB-1:0]       wa_raw, wb_raw, wa_new, wb_new, wb_pad, wf_pad;
	logic [BW-1:0]       bit_a, bit_b;
	logic                src_used, dst_used, src_fixed;
	logic [HANDLE_W-1:0] hsrc;
	status_t             x_status;
	logic                x_hval, x_slot_en;
	logic [HANDLE_W-1:0] x_hout;
	logic                wr_h_en, wr_u_en, take_dst, release_src;
	logic [HANDLE_W-1:0] wr_h_data;
	logic [RW-1:0]       wr_u_row;
	logic [RB-1:0]       wr_u_data;

	always_comb begin
		wa_raw    = row_valid_q[row_a_s1] ? used_rd_a_q : row_init(row_a_s1);
		wb_raw    = row_valid_q[row_b_s1] ? used_rd_b_q : row_init(row_b_s1);
		bit_a     = BW'(idx_a_s1);
		bit_b     = BW'(dst_a_s1);
		src_used  = wa_raw[bit_a];
		dst_used  = wb_raw[bit_b];
		wa_new    = wa_raw & ~(RB'(1) << bit_a);
		wb_new    = wb_raw | (RB'(1) << bit_b);
		wb_pad    = wb_new | pad_of(row_b_s1);
		src_fixed = (32'(idx_a_s1) < 32'(FIXED_SLOTS)) && init_q[idx_a_s1[1:0]];
		hsrc      = src_fixed ? HANDLE_W'(idx_a_s1) : hnd_rd_q;

		x_status    = ST_OK;
		x_hout      = '0;
		x_hval      = 1'b0;
		x_slot_en   = 1'b0;
		take_dst    = 1'b0;
		release_src = 1'b0;

		case (op_s1)
			OP_ALLOC: begin
				if (!dst_ok_s1) begin
					x_status = ST_FULL;
				end else begin
					take_dst = 1'b1;
				end
			end
			OP_FREE: begin
				if (!idx_ok_s1) begin
					x_status = ST_BADIDX;
				end else if (src_used) begin
					x_hout      = hsrc;
					x_hval      = 1'b1;
					release_src = 1'b1;
				end
			end
			OP_CLONE: begin
				if (!idx_ok_s1) begin
					x_status = ST_BADIDX;
				end else if (aut_s1 && !dst_ok_s1) begin
					x_status = ST_FULL;
				end else if (!dst_ok_s1) begin
					x_status = ST_BADIDX;
				end else if (!src_used) begin
					x_status = ST_SRCEMPTY;
				end else if (dst_used) begin
					x_status = ST_TGTBUSY;
				end else begin
					take_dst = 1'b1;
				end
			end
			OP_GET: begin
				if (!idx_ok_s1) begin
					x_status = ST_BADIDX;
				end else if (src_used) begin
					x_hout = hsrc;
					x_hval = 1'b1;
				end
			end
			default: begin
				x_status = ST_OK;
			end
		endcase

		x_slot_en = take_dst;
		wr_h_en   = (state_q == S_EXEC) && take_dst;
		wr_h_data = (op_s1 == OP_ALLOC) ? hin_s1 : hsrc;
		wr_u_en   = (state_q == S_EXEC) && (take_dst || release_src);
		wr_u_row  = take_dst ? row_b_s1 : row_a_s1;
		wr_u_data = take_dst ? wb_new : wa_new;

		wf_pad = (row_valid_q[find_row_q] ? used_rd_b_q : row_init(find_row_q))
		         | pad_of(find_row_q);
	end

	// memories: read every cycle, write back from the execute step
	always_ff @(posedge clk) begin
		hnd_rd_q    <= hnd_mem[in_idx_a];
		used_rd_a_q <= used_mem[in_row_a];
		used_rd_b_q <= used_mem[rd_b_row];
		if (wr_h_en) begin
			hnd_mem[dst_a_s1] <= wr_h_data;
		end
		if (wr_u_en) begin
			used_mem[wr_u_row] <= wr_u_data;
		end
	end

	// request capture and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= in_op;
			hin_s1     <= handle_in;
			aut_s1     <= target_auto;
			idx_ok_s1  <= in_idx_ok;
			dst_ok_s1  <= in_dst_ok;
			dst_low_s1 <= in_dst_low;
			idx_a_s1   <= in_idx_a;
			dst_a_s1   <= in_dst_a;
			row_a_s1   <= in_row_a;
			row_b_s1   <= in_row_b;
		end
		if (state_q == S_EXEC) begin
			status_q <= x_status;
			slot_q   <= x_slot_en ? INDEX_W'(dst_a_s1) : '0;
			hout_q   <= x_hout;
			hval_q   <= x_hval;
		end
		if (state_q == S_FIND) begin
			find_row_q <= find_row;
		end
	end

	// sequencer, counters and row flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_q      <= 1'b0;
			lowest_q    <= IW'(FIXED_SLOTS);
			cnt_q       <= IW'(DEPTH - FIXED_SLOTS);
			row_valid_q <= '0;
			row_full_q  <= '0;
			init_q      <= '1;
		end else begin
			done_q <= (state_q == S_EXEC);
			if (wr_u_en) begin
				row_valid_q[wr_u_row] <= 1'b1;
				row_full_q[wr_u_row]  <= &(wr_u_data | pad_of(wr_u_row));
			end
			if (wr_h_en && (32'(dst_a_s1) < 32'(FIXED_SLOTS))) begin
				init_q[dst_a_s1[1:0]] <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					// the lowest free slot was taken and its row is now full
					if (take_dst && dst_low_s1 && (&wb_pad)) begin
						state_q <= S_FIND;
					end else begin
						state_q <= S_IDLE;
					end
					if (take_dst) begin
						cnt_q <= cnt_q - IW'(1);
						// the lowest free slot was taken: next one is in the same row
						if (dst_low_s1 && !(&wb_pad)) begin
							lowest_q <= IW'((32'(row_b_s1) << BW) | 32'(lz(wb_pad)));
						end
					end
					if (release_src) begin
						cnt_q <= cnt_q + IW'(1);
						if (32'(idx_a_s1) < 32'(lowest_q)) begin
							lowest_q <= IW'(idx_a_s1);
						end
					end
				end
				S_FIND: begin
					if (find_any) begin
						state_q <= S_SCAN;
					end else begin
						lowest_q <= IW'(DEPTH);
						state_q  <= S_IDLE;
					end
				end
				S_SCAN: begin
					lowest_q <= IW'((32'(find_row_q) << BW) | 32'(lz(wf_pad)));
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result ports
	assign done         = done_q;
	assign status       = status_q;
	assign slot_out     = slot_q;
	assign handle_out   = hout_q;
	assign handle_valid = hval_q;
	assign free_count   = COUNT_W'(cnt_q);

endmodule
